### hdl/cma_pkg.sv
// Shared types and constants for the centered moving average unit.
package cma_pkg;

    // Configuration register indexes.
    localparam logic CFG_HALF_WIDTH = 1'b0;
    localparam logic CFG_RECIPROCAL = 1'b1;

    // Register field widths and reset values.
    localparam int HW_FIELD_BITS = 5;
    localparam int RECIP_BITS = 17;
    localparam int CFG_DATA_BITS = 17;
    localparam logic [RECIP_BITS-1:0] RECIP_RESET = 17'd21845;

    // Fraction bits of the reciprocal.
    localparam int FRAC_BITS = 16;

    // Depth of the result queue in front of the output channel.
    localparam int OUT_FIFO_DEPTH = 8;

    // Tag that travels with every result word.
    typedef struct packed {
        logic averaged;
        logic frame_last;
    } res_tag_t;

    // Control bits of one token in the datapath.
    typedef struct packed {
        logic     is_input;
        logic     frame_end;
        logic     sub_en;
        logic     emit;
        res_tag_t tag;
    } tok_flags_t;

endpackage

### hdl/centered_moving_average_unit.sv
// Top level of the centered moving average unit.
//
// Channel   Dir  Handshake          Word contents
// s_*       in   s_tvalid/s_tready  tdata: sample; tlast: frame_end
// m_*       out  m_tvalid/m_tready  tdata: value; tuser: averaged; tlast: frame_last
// cfg_*     in   cfg_wr_en          cfg_addr: register index; cfg_wr_data: value
//
// One sample is accepted every cycle while no flush runs and the result queue has credit;
// the delay memory takes one write and two reads a cycle. A frame end with k pending outputs
// holds the input while the single flush read port drains them, one word a cycle while credit lasts.
// A result word passes the memory read, sum, product and output registers into the result queue.
// Reset is synchronous; the delay memory is not cleared and needs no clearing pass.
// An eight-word result queue with credit accounting absorbs output stalls.
module centered_moving_average_unit #(
    parameter int MAX_HALF_WIDTH = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input stream.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // [SAMPLE_BITS-1:0] sample
    input  logic                                   s_tlast,
    // Result stream.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,   // [SAMPLE_BITS-1:0] value
    output logic                                   m_tuser,   // [0] averaged
    output logic                                   m_tlast,
    // Configuration write port.
    input  logic                                   cfg_wr_en,
    input  logic                                   cfg_addr,
    input  logic [cma_pkg::CFG_DATA_BITS-1:0]      cfg_wr_data
);

    localparam int DEPTH = 2 * MAX_HALF_WIDTH + 2;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int HW_BITS = $clog2(MAX_HALF_WIDTH + 1);
    localparam int CNT_BITS = $clog2(2 * MAX_HALF_WIDTH + 2);
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(2 * MAX_HALF_WIDTH + 1);
    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int FIFO_DEPTH = cma_pkg::OUT_FIFO_DEPTH;
    localparam int CRED_BITS = $clog2(FIFO_DEPTH + 1);
    localparam int RES_BITS = SAMPLE_BITS + $bits(cma_pkg::res_tag_t);

    // Address of the entry written k samples before the one at base.
    function automatic logic [ADDR_BITS-1:0] addr_back(input logic [ADDR_BITS-1:0] base,
                                                       input logic [ADDR_BITS:0] k);
        logic [ADDR_BITS:0] d;
        d = {1'b0, base} - k;
        if (d[ADDR_BITS]) begin
            d = d + (ADDR_BITS + 1)'(DEPTH);
        end
        return d[ADDR_BITS-1:0];
    endfunction

    // Configuration registers.
    logic [HW_BITS-1:0]                 hw_reg;
    logic [cma_pkg::RECIP_BITS-1:0]     recip_reg;
    logic                               cfg_hw_wr;
    logic [cma_pkg::HW_FIELD_BITS-1:0]  cfg_hw_field;

    // Issue stage.
    logic                               s_fire;
    logic                               credit_ok;
    logic                               flush_issue;
    logic                               tok_valid;
    cma_pkg::tok_flags_t                tok_flags;
    logic                               flush_start;
    logic [CNT_BITS:0]                  w_c;
    logic [CNT_BITS:0]                  two_w;
    logic [CNT_BITS:0]                  j_c;
    logic                               in_emit;
    logic                               in_avg;
    logic                               in_sub;
    logic [SAMPLE_BITS-1:0]             s_sample;
    logic [CNT_BITS-1:0]                count_reg;
    logic [ADDR_BITS-1:0]               wp_reg;
    logic                               flush_active_reg;
    logic [HW_BITS-1:0]                 flush_idx_reg;
    logic [ADDR_BITS-1:0]               flush_base_reg;
    logic [CRED_BITS-1:0]               reserved_reg;
    logic [CRED_BITS-1:0]               reserved_next;
    logic [ADDR_BITS-1:0]               rd_a_addr;
    logic [ADDR_BITS-1:0]               rd_b_addr;

    // Delay memory and its read data.
    logic [SAMPLE_BITS-1:0]             dly_mem [DEPTH];
    logic [SAMPLE_BITS-1:0]             rd_a_reg;
    logic [SAMPLE_BITS-1:0]             rd_b_reg;

    // Sum stage.
    logic                               p1_valid_reg;
    cma_pkg::tok_flags_t                p1_flags_reg;
    logic [SAMPLE_BITS-1:0]             p1_sample_reg;
    logic signed [SUM_BITS-1:0]         sum_reg;
    logic signed [SUM_BITS-1:0]         sum_next;

    // Mean stage input registers.
    logic                               p2_valid_reg;
    logic signed [SUM_BITS-1:0]         p2_sum_reg;
    logic [SAMPLE_BITS-1:0]             p2_value_reg;
    cma_pkg::res_tag_t                  p2_tag_reg;

    // Results.
    logic                               res_valid;
    logic [SAMPLE_BITS-1:0]             res_value;
    cma_pkg::res_tag_t                  res_tag;
    logic                               m_fire;
    logic [RES_BITS-1:0]                head_word;
    logic [CRED_BITS-1:0]               fifo_level;

    // Configuration writes; an oversize half width is clamped.
    assign cfg_hw_wr = cfg_wr_en && (cfg_addr == cma_pkg::CFG_HALF_WIDTH);
    assign cfg_hw_field = cfg_wr_data[cma_pkg::HW_FIELD_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hw_reg <= HW_BITS'(1);
            recip_reg <= cma_pkg::RECIP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                cma_pkg::CFG_HALF_WIDTH: begin
                    hw_reg <= (cfg_hw_field > cma_pkg::HW_FIELD_BITS'(MAX_HALF_WIDTH))
                              ? HW_BITS'(MAX_HALF_WIDTH) : HW_BITS'(cfg_hw_field);
                end
                cma_pkg::CFG_RECIPROCAL: begin
                    recip_reg <= cfg_wr_data[cma_pkg::RECIP_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake and credit check against the result queue.
    assign credit_ok = reserved_reg < CRED_BITS'(FIFO_DEPTH);
    assign s_tready = !flush_active_reg && credit_ok;
    assign s_fire = s_tvalid && s_tready;
    assign flush_issue = flush_active_reg && credit_ok;
    assign tok_valid = s_fire || flush_issue;
    assign s_sample = s_tdata[SAMPLE_BITS-1:0];

    // Position of the new sample within its frame.
    assign w_c = (CNT_BITS + 1)'(hw_reg);
    assign two_w = w_c << 1;
    assign j_c = (CNT_BITS + 1)'(count_reg);
    assign in_emit = j_c >= w_c;
    assign in_avg = j_c >= two_w;
    assign in_sub = j_c > two_w;
    assign flush_start = s_tlast && !(in_emit && (hw_reg == '0));

    // Token flags and read addresses for this cycle.
    always_comb begin
        if (flush_active_reg) begin
            tok_flags.is_input = 1'b0;
            tok_flags.frame_end = 1'b0;
            tok_flags.sub_en = 1'b0;
            tok_flags.emit = 1'b1;
            tok_flags.tag.averaged = 1'b0;
            tok_flags.tag.frame_last = (flush_idx_reg == '0);
            rd_b_addr = addr_back(flush_base_reg, (ADDR_BITS + 1)'(flush_idx_reg));
        end else begin
            tok_flags.is_input = 1'b1;
            tok_flags.frame_end = s_tlast;
            tok_flags.sub_en = in_sub;
            tok_flags.emit = in_emit;
            tok_flags.tag.averaged = in_avg;
            tok_flags.tag.frame_last = s_tlast && (hw_reg == '0);
            rd_b_addr = addr_back(wp_reg, (ADDR_BITS + 1)'(hw_reg));
        end
        rd_a_addr = addr_back(wp_reg, (ADDR_BITS + 1)'(two_w + 1'b1));
    end

    // Frame counter, write pointer and flush sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            wp_reg <= '0;
            flush_active_reg <= 1'b0;
            flush_idx_reg <= '0;
            flush_base_reg <= '0;
        end else begin
            if (cfg_hw_wr) begin
                count_reg <= '0;
            end else if (s_fire) begin
                if (s_tlast) begin
                    count_reg <= '0;
                end else if (count_reg != '1) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (s_fire) begin
                wp_reg <= (wp_reg == ADDR_BITS'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (s_fire && flush_start) begin
                flush_active_reg <= 1'b1;
                flush_base_reg <= wp_reg;
                flush_idx_reg <= in_emit ? hw_reg - 1'b1 : count_reg[HW_BITS-1:0];
            end else if (flush_issue) begin
                if (flush_idx_reg == '0) begin
                    flush_active_reg <= 1'b0;
                end else begin
                    flush_idx_reg <= flush_idx_reg - 1'b1;
                end
            end
        end
    end

    // Credits: result words issued and not yet taken by the output side.
    assign m_fire = m_tvalid && m_tready;
    assign reserved_next = reserved_reg + CRED_BITS'(tok_valid && tok_flags.emit)
                           - CRED_BITS'(m_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserved_reg <= '0;
        end else begin
            reserved_reg <= reserved_next;
        end
    end

    // Delay memory: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            dly_mem[wp_reg] <= s_sample;
        end
        rd_a_reg <= dly_mem[rd_a_addr];
        rd_b_reg <= dly_mem[rd_b_addr];
    end

    // Token registers alongside the memory read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= tok_valid;
        end
        p1_flags_reg <= tok_flags;
        p1_sample_reg <= s_sample;
    end

    // Running window sum: add the new sample, drop the oldest one.
    assign sum_next = sum_reg + SUM_BITS'($signed(p1_sample_reg))
                      - (p1_flags_reg.sub_en ? SUM_BITS'($signed(rd_a_reg))
                                             : SUM_BITS'(0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (cfg_hw_wr) begin
            sum_reg <= '0;
        end else if (p1_valid_reg && p1_flags_reg.is_input) begin
            sum_reg <= p1_flags_reg.frame_end ? '0 : sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= p1_valid_reg && p1_flags_reg.emit;
        end
        p2_sum_reg <= sum_next;
        p2_value_reg <= rd_b_reg;
        p2_tag_reg <= p1_flags_reg.tag;
    end

    cma_mean #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_mean (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p2_valid_reg),
        .in_sum    (p2_sum_reg),
        .in_value  (p2_value_reg),
        .in_tag    (p2_tag_reg),
        .recip     (recip_reg),
        .out_valid (res_valid),
        .out_value (res_value),
        .out_tag   (res_tag)
    );

    cma_out_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data ({res_tag, res_value}),
        .pop       (m_fire),
        .out_valid (m_tvalid),
        .out_data  (head_word),
        .level     (fifo_level)
    );

    // Output word fields.
    assign m_tdata = TDATA_BITS'(head_word[SAMPLE_BITS-1:0]);
    assign m_tuser = head_word[SAMPLE_BITS + 1];
    assign m_tlast = head_word[SAMPLE_BITS];

`ifndef SYNTH
    // Credits never exceed the queue depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        reserved_reg <= CRED_BITS'(FIFO_DEPTH))
        else $error("credit count exceeds result queue depth");

    // Every queued word was reserved at issue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_level <= reserved_reg)
        else $error("result queue holds unreserved words");

    // A frame end with pending outputs starts the flush.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && flush_start) |=> flush_active_reg)
        else $error("flush not started after frame end");

    // Flush tokens leave the window sum alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !p1_flags_reg.is_input && !cfg_wr_en) |=> $stable(sum_reg))
        else $error("window sum changed by a flush token");
`endif

endmodule

### hdl/cma_mean.sv
// Window mean: multiply by the reciprocal, round to nearest and saturate; other words pass through.
module cma_mean #(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_BITS = 22
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    input  logic signed [SUM_BITS-1:0]          in_sum,
    input  logic [SAMPLE_BITS-1:0]              in_value,
    input  cma_pkg::res_tag_t                   in_tag,
    input  logic [cma_pkg::RECIP_BITS-1:0]      recip,
    output logic                                out_valid,
    output logic [SAMPLE_BITS-1:0]              out_value,
    output cma_pkg::res_tag_t                   out_tag
);

    localparam int PROD_BITS = SUM_BITS + cma_pkg::RECIP_BITS + 1;
    localparam int RND_BITS = PROD_BITS + 1;
    localparam logic signed [RND_BITS-1:0] SAT_HI =
        RND_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [RND_BITS-1:0] SAT_LO = -SAT_HI - RND_BITS'(1);
    localparam logic signed [RND_BITS-1:0] HALF_LSB =
        RND_BITS'(64'sd1 <<< (cma_pkg::FRAC_BITS - 1));

    logic                         p_valid_reg;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic signed [PROD_BITS-1:0]  prod_next;
    logic [SAMPLE_BITS-1:0]       p_value_reg;
    cma_pkg::res_tag_t            p_tag_reg;
    logic signed [RND_BITS-1:0]   rnd;
    logic [SAMPLE_BITS-1:0]       sat_value;
    logic                         out_valid_reg;
    logic [SAMPLE_BITS-1:0]       out_value_reg;
    cma_pkg::res_tag_t            out_tag_reg;

    // Signed sum times the unsigned reciprocal.
    assign prod_next = in_sum * $signed({1'b0, recip});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= in_valid;
        end
        prod_reg <= prod_next;
        p_value_reg <= in_value;
        p_tag_reg <= in_tag;
    end

    // Round half up, then clamp to the sample range.
    always_comb begin
        rnd = (RND_BITS'(prod_reg) + HALF_LSB) >>> cma_pkg::FRAC_BITS;
        if (rnd > SAT_HI) begin
            sat_value = SAT_HI[SAMPLE_BITS-1:0];
        end else if (rnd < SAT_LO) begin
            sat_value = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            sat_value = rnd[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= p_valid_reg;
        end
        out_value_reg <= p_tag_reg.averaged ? sat_value : p_value_reg;
        out_tag_reg <= p_tag_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_tag = out_tag_reg;

endmodule

### hdl/cma_out_fifo.sv
// Result queue that decouples the datapath from output stalls.
module cma_out_fifo #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic                       out_valid,
    output logic [WIDTH-1:0]           out_data,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int LVL_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [LVL_BITS-1:0] level_reg;
    logic                do_pop;

    assign do_pop = pop && (level_reg != '0);

    // Storage; pushes are never issued to a full queue.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
            end
            level_reg <= level_reg + LVL_BITS'(push) - LVL_BITS'(do_pop);
        end
    end

    assign out_valid = (level_reg != '0);
    assign out_data = entry_reg[rd_ptr_reg];
    assign level = level_reg;

endmodule

### sim/tb.sv
// Self-checking testbench for the centered moving average unit.
`timescale 1ns / 1ps

module tb;

    localparam int SAMPLE_W = 16;
    localparam int TAPS = 33;
    localparam int DIRECTED_ITEMS = 26;
    localparam int RANDOM_ITEMS = 140;
    localparam int SETTLE_CYCLES = 20;
    localparam int QUIET_LIMIT = 4000;

    // One result word as it leaves the block.
    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                averaged;
        logic                frame_last;
    } avg_word_t;

    // Predicts the filter output and checks every result word against it.
    class average_scoreboard;
        logic signed [SAMPLE_W-1:0]     taps [0:TAPS-1];
        longint                         window_acc;
        int unsigned                    frame_pos;
        int unsigned                    half_w;
        logic [cma_pkg::RECIP_BITS-1:0] recip;
        avg_word_t                      expected_words [$];
        int unsigned                    errors;
        int unsigned                    words_seen;

        function new();
            for (int k = 0; k < TAPS; k++) taps[k] = '0;
            window_acc = 0;
            frame_pos = 0;
            half_w = 1;
            recip = cma_pkg::RECIP_RESET;
            errors = 0;
            words_seen = 0;
        endfunction

        // A half width write also drops the frame in progress.
        function void write_reg(logic idx, logic [cma_pkg::CFG_DATA_BITS-1:0] val);
            if (idx == cma_pkg::CFG_HALF_WIDTH) begin
                half_w = (val[4:0] > 5'd16) ? 16 : val[4:0];
                frame_pos = 0;
                window_acc = 0;
            end else begin
                recip = val[cma_pkg::RECIP_BITS-1:0];
            end
        endfunction

        // Window sum times the reciprocal, rounded half up, then saturated.
        function logic [SAMPLE_W-1:0] mean_of(longint acc);
            longint prod;
            longint rounded;
            prod = acc * longint'(recip);
            rounded = (prod + 32768) >>> cma_pkg::FRAC_BITS;
            if (rounded > 32767) rounded = 32767;
            else if (rounded < -32768) rounded = -32768;
            return rounded[SAMPLE_W-1:0];
        endfunction

        function void push_word(logic [SAMPLE_W-1:0] v, logic avg, logic last);
            avg_word_t word;
            word.value = v;
            word.averaged = avg;
            word.frame_last = last;
            expected_words.push_back(word);
        endfunction

        // Advance the window by one accepted sample and queue what it releases.
        function void note_sample(logic [SAMPLE_W-1:0] smp, logic eof);
            int unsigned w;
            int unsigned j;
            int          first;
            logic        avg;
            w = half_w;
            j = frame_pos;
            if (j >= 2 * w + 1) window_acc -= taps[2 * w];
            for (int k = TAPS - 1; k > 0; k--) taps[k] = taps[k - 1];
            taps[0] = smp;
            window_acc += taps[0];
            if (j >= w) begin
                avg = (j >= 2 * w);
                push_word(avg ? mean_of(window_acc) : taps[w], avg, eof && (w == 0));
            end
            if (eof) begin
                // The tail of the frame is flushed oldest first, as passthroughs.
                first = (j >= w) ? int'(w) : int'(j + 1);
                for (int k = first - 1; k >= 0; k--) push_word(taps[k], 1'b0, k == 0);
                frame_pos = 0;
                window_acc = 0;
            end else if (j < 63) begin
                frame_pos = j + 1;
            end
        endfunction

        function void check_word(logic [SAMPLE_W-1:0] v, logic avg, logic last);
            avg_word_t want;
            words_seen++;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: value %0d averaged %0b last %0b",
                         $time, $signed(v), avg, last);
                return;
            end
            want = expected_words.pop_front();
            if (v !== want.value || avg !== want.averaged || last !== want.frame_last) begin
                errors++;
                $display("%0t: word mismatch: expected value %0d averaged %0b last %0b",
                         $time, $signed(want.value), want.averaged, want.frame_last);
                $display("%0t:                actual value %0d averaged %0b last %0b",
                         $time, $signed(v), avg, last);
            end
        endfunction
    endclass

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [SAMPLE_W-1:0]               s_tdata = '0;
    logic                              s_tlast = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [SAMPLE_W-1:0]               m_tdata;
    logic                              m_tuser;
    logic                              m_tlast;
    logic                              cfg_wr_en = 1'b0;
    logic                              cfg_addr = cma_pkg::CFG_HALF_WIDTH;
    logic [cma_pkg::CFG_DATA_BITS-1:0] cfg_wr_data = '0;

    average_scoreboard sb;
    bit                no_gaps = 1'b0;
    int unsigned       sent = 0;
    int unsigned       settings = 0;
    int unsigned       quiet = 0;

    centered_moving_average_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // The receiver stalls now and then, except during the gap-free phase.
    always @(posedge aclk) begin
        m_tready <= no_gaps || ($urandom_range(0, 99) >= 9);
    end

    // Both handshakes are sampled here, and a watchdog guards against a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_sample(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser, m_tlast);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet = 0;
        end else begin
            quiet = quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: watchdog expired with %0d words outstanding",
                         $time, sb.expected_words.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Offer one sample word and hold it until the block takes it.
    task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic eof);
        while (!no_gaps && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        s_tlast <= eof;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    // Samples lean toward the extremes of the range.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        unique case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frame(input int len, input bit closed);
        for (int k = 0; k < len; k++) push_sample(pick_sample(), closed && k == len - 1);
    endtask

    // Stop sending, let every expected word arrive, then let the pipeline settle.
    // The first edge makes sure the monitor has noted the last accepted sample.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [cma_pkg::CFG_DATA_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic apply_setting(input int w, input logic [cma_pkg::RECIP_BITS-1:0] r);
        write_reg(cma_pkg::CFG_HALF_WIDTH, cma_pkg::CFG_DATA_BITS'(w));
        write_reg(cma_pkg::CFG_RECIPROCAL, r);
        settings++;
    endtask

    initial begin
        int                             phase;
        int                             w;
        int                             eff;
        int                             len;
        int unsigned                    phase_start;
        logic [cma_pkg::RECIP_BITS-1:0] r;

        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setting: frames shorter than the window and full-scale frames.
        push_sample(16'h7FFF, 1'b1);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7FFF, 1'b1);
        for (int k = 0; k < 5; k++) push_sample(16'h7FFF, k == 4);
        for (int k = 0; k < 4; k++) push_sample(16'h8000, k == 3);

        // Zero half width with unity gain returns every sample, marked averaged.
        wait_idle();
        apply_setting(0, 17'd65536);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h1234, 1'b1);

        // Largest reciprocal drives the mean into saturation at both ends.
        wait_idle();
        apply_setting(1, 17'h1FFFF);
        for (int k = 0; k < 3; k++) push_sample(16'h7FFF, k == 2);
        for (int k = 0; k < 3; k++) push_sample(16'h8000, k == 2);

        // A zero reciprocal gives a zero mean.
        wait_idle();
        apply_setting(2, 17'd0);
        send_frame(5, 1'b1);

        // Random frames under a sequence of settings, widest window first.
        phase = 0;
        while (sent < DIRECTED_ITEMS + RANDOM_ITEMS || phase < 4) begin
            wait_idle();
            unique case (phase)
                0: begin w = 16; r = 17'd1986; end
                1: begin w = 31; r = 17'd1; end
                2: begin w = 0; r = 17'h1FFFF; end
                default: begin
                    w = $urandom_range(0, 6);
                    if ($urandom_range(0, 9) == 0) r = 17'($urandom);
                    else r = 17'((65536 + w) / (2 * w + 1));
                end
            endcase
            no_gaps = (phase == 3);
            apply_setting(w, r);
            eff = (w > 16) ? 16 : w;
            phase_start = sent;
            while (sent - phase_start < 24) begin
                if ($urandom_range(0, 4) == 0) len = $urandom_range(1, eff + 1);
                else len = $urandom_range(2 * eff + 1, 2 * eff + 6);
                send_frame(len, 1'b1);
            end
            // Sometimes leave a frame open; the next half width write drops it.
            if ($urandom_range(0, 3) == 0) send_frame($urandom_range(1, 2 * eff + 3), 1'b0);
            phase++;
        end

        no_gaps = 1'b0;
        wait_idle();
        if (sb.expected_words.size() != 0) sb.errors++;
        $display("Run covered %0d samples and %0d result words under %0d settings.",
                 sent, sb.words_seen, settings);
        $display("Mismatches found: %0d.", sb.errors);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
